### rtl/lisp_token_lexer_defines.svh
// ----------------------------------------------------------------------------
// lisp_token_lexer_defines
// Assertion macros used by the lexer RTL (the token queue).
// ----------------------------------------------------------------------------
`ifndef LISP_TOKEN_LEXER_DEFINES_SVH
`define LISP_TOKEN_LEXER_DEFINES_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define LTL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define LTL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ltl_pkg.sv
// ----------------------------------------------------------------------------
// ltl_pkg
// Types, codes and character class helpers for the token lexer.
// ----------------------------------------------------------------------------
package ltl_pkg;

    localparam int unsigned PositionBitsDefault = 16;
    localparam int unsigned FieldBits = 16;
    localparam int unsigned QueueDepth = 4;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_COMMENT,
        MODE_WORD,
        MODE_STRING
    } t_mode;

    typedef enum logic [3:0] {
        FS_START,
        FS_SIGN,
        FS_INT,
        FS_DOT,
        FS_FRAC,
        FS_E,
        FS_ESIGN,
        FS_EXP,
        FS_DEAD
    } t_fstate;

    localparam logic [4:0] KIND_NUMBER = 5'd6;
    localparam logic [4:0] KIND_BOOL   = 5'd7;
    localparam logic [4:0] KIND_CHAR   = 5'd8;
    localparam logic [4:0] KIND_STRING = 5'd9;
    localparam logic [4:0] KIND_DEFINE = 5'd10;
    localparam logic [4:0] KIND_LET    = 5'd11;
    localparam logic [4:0] KIND_COND   = 5'd12;
    localparam logic [4:0] KIND_IF     = 5'd13;
    localparam logic [4:0] KIND_BEGIN  = 5'd14;
    localparam logic [4:0] KIND_IDENT  = 5'd15;
    localparam logic [4:0] KIND_ERROR  = 5'd16;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    // One token as it travels from the scanner to the output side.
    typedef struct packed {
        logic [4:0]           kind;
        logic [FieldBits-1:0] row;
        logic [FieldBits-1:0] col;
        logic [FieldBits-1:0] len;
        logic                 last;
    } t_token;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_low(input logic [7:0] c);
        return c >= "a" && c <= "z";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic logic is_e(input logic [7:0] c);
        return c == "e" || c == "E";
    endfunction

    function automatic logic is_bracket(input logic [7:0] c);
        return c == "(" || c == ")" || c == "[" || c == "]" || c == "{" || c == "}";
    endfunction

    function automatic logic [4:0] bracket_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            "(":     k = 5'd0;
            ")":     k = 5'd1;
            "[":     k = 5'd2;
            "]":     k = 5'd3;
            "{":     k = 5'd4;
            default: k = 5'd5;
        endcase
        return k;
    endfunction

    function automatic t_fstate float_next(input t_fstate s, input logic [7:0] c);
        t_fstate n;
        n = FS_DEAD;
        unique case (s)
            FS_START: begin
                if (is_sign(c)) n = FS_SIGN;
                else if (is_dig(c)) n = FS_INT;
                else if (c == ".") n = FS_DOT;
            end
            FS_SIGN, FS_INT: begin
                if (is_dig(c)) n = FS_INT;
                else if (c == ".") n = FS_DOT;
                else if (is_e(c)) n = FS_E;
            end
            FS_DOT: if (is_dig(c)) n = FS_FRAC;
            FS_FRAC: begin
                if (is_dig(c)) n = FS_FRAC;
                else if (is_e(c)) n = FS_E;
            end
            FS_E: begin
                if (is_sign(c)) n = FS_ESIGN;
                else if (is_dig(c)) n = FS_EXP;
            end
            FS_ESIGN, FS_EXP: if (is_dig(c)) n = FS_EXP;
            default: n = FS_DEAD;
        endcase
        return n;
    endfunction

endpackage

### rtl/lisp_token_lexer.sv
// ----------------------------------------------------------------------------
// lisp_token_lexer
// Streaming Lisp lexer: source bytes in, classified tokens out.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload
// input    i_valid / o_ready     i_char_byte, i_end_of_input
// output   o_valid / i_ready     o_token_kind, o_start_row, o_start_column,
//                                o_token_length, o_last_of_run
// One byte is taken each cycle while the token queue has two free slots.
// The scanner updates all recognizers in the cycle a byte is accepted;
// tokens are written into the token queue and leave it one per cycle while i_ready is high.
// A byte ending a word at a bracket yields two tokens; the output drains one
// a cycle while i_ready is high, so input waits whenever two slots are not free.
// Reset is synchronous and clears mode, positions and the queue.
// ----------------------------------------------------------------------------
module lisp_token_lexer #(
    parameter int unsigned POSITION_BITS = ltl_pkg::PositionBitsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_byte,
    input  logic        i_end_of_input,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_start_row,
    output logic [15:0] o_start_column,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import ltl_pkg::*;

    logic       step, room2;
    logic [1:0] count, push;
    t_token     tok0, tok1, head;

    assign o_ready = room2;
    assign step    = i_valid && room2;
    assign push    = step ? count : 2'd0;

    ltl_scanner #(.POSITION_BITS(POSITION_BITS)) u_scan (
        .i_clk, .i_rst_n, .i_step(step), .i_char_byte, .i_end_of_input,
        .o_count(count), .o_tok0(tok0), .o_tok1(tok1)
    );

    ltl_queue u_queue (
        .i_clk, .i_rst_n, .i_push_count(push), .i_tok0(tok0), .i_tok1(tok1),
        .o_room2(room2), .o_valid(o_valid), .o_tok(head), .i_pop(i_ready)
    );

    assign o_token_kind   = head.kind;
    assign o_start_row    = head.row;
    assign o_start_column = head.col;
    assign o_token_length = head.len;
    assign o_last_of_run  = head.last;

endmodule

### rtl/ltl_scanner.sv
// ----------------------------------------------------------------------------
// ltl_scanner
// Front end: tracks position and scan mode, runs the recognizers and
// produces up to two finished tokens per source byte.
// ----------------------------------------------------------------------------
module ltl_scanner #(
    parameter int unsigned POSITION_BITS = ltl_pkg::PositionBitsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  logic [7:0]      i_char_byte,
    input  logic            i_end_of_input,
    output logic [1:0]      o_count,
    output ltl_pkg::t_token o_tok0,
    output ltl_pkg::t_token o_tok1
);
    import ltl_pkg::*;

    localparam logic [POSITION_BITS-1:0] PosMax = '1;
    localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

    t_mode                  r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_col, n_col;
    logic [POSITION_BITS-1:0] r_srow, n_srow;
    logic [POSITION_BITS-1:0] r_scol, n_scol;
    logic [POSITION_BITS-1:0] r_cnt, n_cnt;
    logic [7:0]             r_lead [6];
    logic [7:0]             n_lead [6];
    t_fstate                r_fs, n_fs;
    logic                   r_hex, n_hex, r_bin, n_bin, r_idt, n_idt;
    logic                   r_sok, n_sok, r_esc, n_esc, r_eq, n_eq;

    logic [7:0] c;
    logic [4:0] word_kind;

    assign c = i_char_byte;

    function automatic logic [FieldBits-1:0] clamp(input logic [POSITION_BITS-1:0] v);
        logic [FieldBits-1:0] r;
        if (POSITION_BITS > FieldBits) begin
            r = (v > POSITION_BITS'({FieldBits{1'b1}})) ? '1 : FieldBits'(v);
        end else begin
            r = FieldBits'(v);
        end
        return r;
    endfunction

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        return (v == PosMax) ? v : v + PosOne;
    endfunction

    function automatic logic cnt_is(input logic [POSITION_BITS-1:0] v, input int unsigned k);
        return v == POSITION_BITS'(k);
    endfunction

    // Kind of the word held in the registers, by fixed priority.
    always_comb begin
        logic px;
        logic l3, l4, l5, l6, l2;
        px = (r_cnt >= POSITION_BITS'(3)) && (r_lead[0] == "0");
        l2 = cnt_is(r_cnt, 2);
        l3 = cnt_is(r_cnt, 3);
        l4 = cnt_is(r_cnt, 4);
        l5 = cnt_is(r_cnt, 5);
        l6 = cnt_is(r_cnt, 6);
        priority if (r_fs == FS_INT || r_fs == FS_FRAC || r_fs == FS_EXP) begin
            word_kind = KIND_NUMBER;
        end else if (px && r_lead[1] == "x" && r_hex) begin
            word_kind = KIND_NUMBER;
        end else if (px && r_lead[1] == "b" && r_bin) begin
            word_kind = KIND_NUMBER;
        end else if ((l4 && r_lead[0] == "t" && r_lead[1] == "r" && r_lead[2] == "u"
                && r_lead[3] == "e") || (l5 && r_lead[0] == "f" && r_lead[1] == "a"
                && r_lead[2] == "l" && r_lead[3] == "s" && r_lead[4] == "e")) begin
            word_kind = KIND_BOOL;
        end else if (r_cnt >= POSITION_BITS'(3) && r_lead[0] == "'" && r_lead[1] >= 8'd32
                && r_lead[1] <= 8'd126 && r_lead[2] == "'") begin
            word_kind = KIND_CHAR;
        end else if (l6 && r_lead[0] == "d" && r_lead[1] == "e" && r_lead[2] == "f"
                && r_lead[3] == "i" && r_lead[4] == "n" && r_lead[5] == "e") begin
            word_kind = KIND_DEFINE;
        end else if (l3 && r_lead[0] == "l" && r_lead[1] == "e" && r_lead[2] == "t") begin
            word_kind = KIND_LET;
        end else if (l4 && r_lead[0] == "c" && r_lead[1] == "o" && r_lead[2] == "n"
                && r_lead[3] == "d") begin
            word_kind = KIND_COND;
        end else if (l2 && r_lead[0] == "i" && r_lead[1] == "f") begin
            word_kind = KIND_IF;
        end else if (l5 && r_lead[0] == "b" && r_lead[1] == "e" && r_lead[2] == "g"
                && r_lead[3] == "i" && r_lead[4] == "n") begin
            word_kind = KIND_BEGIN;
        end else if (is_sign(r_lead[0]) || r_lead[0] == ".") begin
            word_kind = cnt_is(r_cnt, 1) ? KIND_IDENT : KIND_ERROR;
        end else if ((is_low(r_lead[0]) || r_lead[0] == "!" || r_lead[0] == "*"
                || r_lead[0] == "/" || r_lead[0] == ":" || r_lead[0] == "<"
                || r_lead[0] == "=" || r_lead[0] == ">" || r_lead[0] == "?") && r_idt) begin
            word_kind = KIND_IDENT;
        end else begin
            word_kind = KIND_ERROR;
        end
    end

    always_comb begin
        t_token tk_word, tk_now;
        logic   start_word, start_str, go_idle_byte;
        logic [POSITION_BITS-1:0] cnt_base;
        n_mode = r_mode;
        n_line = r_line;
        n_col  = r_col;
        n_srow = r_srow;
        n_scol = r_scol;
        n_cnt  = r_cnt;
        n_lead = r_lead;
        n_fs   = r_fs;
        n_hex  = r_hex;
        n_bin  = r_bin;
        n_idt  = r_idt;
        n_sok  = r_sok;
        n_esc  = r_esc;
        n_eq   = r_eq;
        o_count = 2'd0;
        start_word = 1'b0;
        start_str  = 1'b0;
        go_idle_byte = 1'b0;
        cnt_base = PosOne;

        tk_word.kind = word_kind;
        tk_word.row  = clamp(r_srow);
        tk_word.col  = clamp(r_scol);
        tk_word.len  = clamp(r_cnt);
        tk_word.last = 1'b1;
        tk_now = tk_word;
        o_tok0 = tk_word;
        o_tok1 = tk_word;

        if (i_end_of_input) begin
            if (r_mode == MODE_WORD) begin
                o_count = 2'd1;
            end else if (r_mode == MODE_STRING) begin
                o_tok0.kind = (cnt_is(r_cnt, 1) || (!r_esc && r_eq && r_sok))
                              ? KIND_STRING : KIND_ERROR;
                o_count = 2'd1;
            end
            n_mode = MODE_IDLE;
            n_line = PosOne;
            n_col  = '0;
            n_srow = PosOne;
            n_scol = '0;
            n_cnt  = '0;
            for (int i = 0; i < 6; i++) n_lead[i] = 8'd0;
            n_fs  = FS_START;
            n_hex = 1'b1;
            n_bin = 1'b1;
            n_idt = 1'b1;
            n_sok = 1'b1;
            n_esc = 1'b0;
            n_eq  = 1'b0;
        end else begin
            if (c == CH_NL) begin
                n_line = sat_inc(r_line);
                n_col  = '0;
            end else begin
                n_col = sat_inc(r_col);
            end
            unique case (r_mode)
                MODE_COMMENT: if (c == CH_NL) n_mode = MODE_IDLE;
                MODE_STRING: begin
                    n_cnt = sat_inc(r_cnt);
                    if (r_esc) begin
                        if (c != CH_QUOTE && c != CH_BSL && c != "n" && c != "r" && c != "t")
                            n_sok = 1'b0;
                        n_esc = 1'b0;
                        n_eq  = (c == CH_QUOTE);
                    end else if (c == CH_QUOTE) begin
                        o_tok0.kind = r_sok ? KIND_STRING : KIND_ERROR;
                        o_tok0.len  = clamp(n_cnt);
                        o_count = 2'd1;
                        n_mode = MODE_IDLE;
                    end else if (c == CH_BSL) begin
                        n_esc = 1'b1;
                        n_eq  = 1'b0;
                    end else begin
                        if (c < 8'd32 || c > 8'd126) n_sok = 1'b0;
                        n_eq = 1'b0;
                    end
                end
                MODE_WORD: begin
                    if (is_blank(c)) begin
                        o_count = 2'd1;
                        n_mode = MODE_IDLE;
                    end else if (is_bracket(c)) begin
                        tk_now.kind = bracket_kind(c);
                        tk_now.row  = clamp(n_line);
                        tk_now.col  = clamp(n_col);
                        tk_now.len  = FieldBits'(1);
                        o_tok0.last = 1'b0;
                        o_tok1 = tk_now;
                        o_count = 2'd2;
                        n_mode = MODE_IDLE;
                    end else begin
                        go_idle_byte = 1'b0;
                        n_fs = float_next(r_fs, c);
                        if (r_cnt >= POSITION_BITS'(2)) begin
                            if (!is_hex(c)) n_hex = 1'b0;
                            if (c != "0" && c != "1") n_bin = 1'b0;
                        end
                        if (!(is_low(c) || is_dig(c) || c == "." || is_sign(c)))
                            n_idt = 1'b0;
                        for (int i = 0; i < 6; i++)
                            if (r_cnt == POSITION_BITS'(i)) n_lead[i] = c;
                        n_cnt = sat_inc(r_cnt);
                    end
                end
                default: go_idle_byte = 1'b1;
            endcase
            if (go_idle_byte && !is_blank(c)) begin
                if (c == CH_TILDE) begin
                    n_mode = MODE_COMMENT;
                end else if (is_bracket(c)) begin
                    o_tok0.kind = bracket_kind(c);
                    o_tok0.row  = clamp(n_line);
                    o_tok0.col  = clamp(n_col);
                    o_tok0.len  = FieldBits'(1);
                    o_count = 2'd1;
                end else if (c == CH_QUOTE) begin
                    start_str = 1'b1;
                end else begin
                    start_word = 1'b1;
                end
            end
            if (start_str || start_word) begin
                n_srow = n_line;
                n_scol = n_col;
                for (int i = 0; i < 6; i++) n_lead[i] = 8'd0;
                n_hex = 1'b1;
                n_bin = 1'b1;
                n_sok = 1'b1;
                n_esc = 1'b0;
                n_eq  = 1'b0;
                n_idt = 1'b1;
                n_fs  = FS_START;
                n_cnt = cnt_base;
                if (start_str) begin
                    n_mode = MODE_STRING;
                end else begin
                    n_mode = MODE_WORD;
                    n_fs = float_next(FS_START, c);
                    n_lead[0] = c;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_line <= PosOne;
            r_col  <= '0;
            r_srow <= PosOne;
            r_scol <= '0;
            r_cnt  <= '0;
            for (int i = 0; i < 6; i++) r_lead[i] <= 8'd0;
            r_fs  <= FS_START;
            r_hex <= 1'b1;
            r_bin <= 1'b1;
            r_idt <= 1'b1;
            r_sok <= 1'b1;
            r_esc <= 1'b0;
            r_eq  <= 1'b0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_srow <= n_srow;
            r_scol <= n_scol;
            r_cnt  <= n_cnt;
            r_lead <= n_lead;
            r_fs  <= n_fs;
            r_hex <= n_hex;
            r_bin <= n_bin;
            r_idt <= n_idt;
            r_sok <= n_sok;
            r_esc <= n_esc;
            r_eq  <= n_eq;
        end
    end

endmodule

### rtl/ltl_queue.sv
// ----------------------------------------------------------------------------
// ltl_queue
// Token queue between scanner and output; takes up to two tokens a cycle
// and hands out one.
// ----------------------------------------------------------------------------
`include "lisp_token_lexer_defines.svh"

module ltl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_count,
    input  ltl_pkg::t_token i_tok0,
    input  ltl_pkg::t_token i_tok1,
    output logic            o_room2,
    output logic            o_valid,
    output ltl_pkg::t_token o_tok,
    input  logic            i_pop
);
    import ltl_pkg::*;

    localparam int unsigned PtrBits = $clog2(QueueDepth);

    t_token               r_mem [QueueDepth];
    logic [PtrBits-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [PtrBits:0]     r_fill, n_fill;
    logic                 pop_ok;

    assign pop_ok  = i_pop && (r_fill != '0);
    assign o_valid = (r_fill != '0);
    assign o_tok   = r_mem[r_rd];
    // A free pair of slots is kept so a word plus bracket always fits.
    assign o_room2 = (r_fill <= (PtrBits+1)'(QueueDepth - 2));

    always_comb begin
        n_wr   = r_wr + PtrBits'(i_push_count);
        n_rd   = r_rd + PtrBits'(pop_ok);
        n_fill = r_fill + (PtrBits+1)'(i_push_count) - (PtrBits+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_mem[r_wr] <= i_tok0;
        if (i_push_count == 2'd2) r_mem[r_wr + PtrBits'(1)] <= i_tok1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_fill <= n_fill;
        end
    end

    `LTL_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push_count == 2'd2,
        r_fill <= (PtrBits+1)'(QueueDepth - 2), "token queue overflow")
    `LTL_ASSERT_IMPLY(a_push_range, i_clk, i_rst_n, 1'b1,
        i_push_count != 2'd3, "invalid push count")
    `LTL_ASSERT_NEXT(a_fill_track, i_clk, i_rst_n,
        i_push_count == 2'd0 && pop_ok, r_fill == $past(r_fill) - 1'b1, "fill count slip")

endmodule

### verif/lisp_token_lexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lisp_token_lexer_tb
// Feeds source bytes and end markers to the lexer and checks every token it
// reports (kind, start row and column, length, last-of-run flag) against a
// token model kept in step with the accepted input bytes.
// ----------------------------------------------------------------------------
module lisp_token_lexer_tb;
    import ltl_pkg::*;

    localparam logic [4:0] KIND_LPAREN = 5'd0;
    localparam logic [4:0] KIND_RPAREN = 5'd1;
    localparam logic [4:0] KIND_LBRACK = 5'd2;
    localparam logic [4:0] KIND_RBRACK = 5'd3;
    localparam logic [4:0] KIND_LBRACE = 5'd4;
    localparam logic [4:0] KIND_RBRACE = 5'd5;
    localparam int unsigned CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
    } src_item_t;

    typedef struct {
        logic [4:0]  kind;
        logic [15:0] row;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } token_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_char_byte = 8'd0;
    logic        i_end_of_input = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [4:0]  o_token_kind;
    logic [15:0] o_start_row;
    logic [15:0] o_start_column;
    logic [15:0] o_token_length;
    logic        o_last_of_run;

    src_item_t   pending_bytes[$];
    token_t      expected_tokens[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned accepted_count = 0;
    bit          running = 1'b0;
    bit          gaps_on = 1'b1;
    bit          byte_taken = 1'b0;
    int unsigned src_gap = 0;
    int unsigned sink_gap = 0;
    bit          hold_done = 1'b0;

    // Lexer state as the token model sees it.
    t_mode       lx_mode;
    logic [15:0] lx_line, lx_col, lx_tok_row, lx_tok_col, lx_count;
    logic [7:0]  lx_lead[6];
    t_fstate     lx_fs;
    bit          lx_hex, lx_bin, lx_idt, lx_sok, lx_esc, lx_eq;
    token_t      step_tokens[$];

    lisp_token_lexer i_dut (.*);

    always #2 i_clk = ~i_clk;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit blank_ch(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic bit lower_ch(input logic [7:0] c);
        return c >= 8'h61 && c <= 8'h7A;
    endfunction

    function automatic bit sign_ch(input logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic bit exp_ch(input logic [7:0] c);
        return c == "e" || c == "E";
    endfunction

    function automatic bit brack_ch(input logic [7:0] c, output logic [4:0] k);
        k = KIND_LPAREN;
        case (c)
            "(": k = KIND_LPAREN;
            ")": k = KIND_RPAREN;
            "[": k = KIND_LBRACK;
            "]": k = KIND_RBRACK;
            "{": k = KIND_LBRACE;
            "}": k = KIND_RBRACE;
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_fstate number_step(input t_fstate s, input logic [7:0] c);
        case (s)
            FS_START: return sign_ch(c) ? FS_SIGN : digit_ch(c) ? FS_INT :
                             (c == ".") ? FS_DOT : FS_DEAD;
            FS_SIGN, FS_INT: return digit_ch(c) ? FS_INT : (c == ".") ? FS_DOT :
                                    exp_ch(c) ? FS_E : FS_DEAD;
            FS_DOT: return digit_ch(c) ? FS_FRAC : FS_DEAD;
            FS_FRAC: return digit_ch(c) ? FS_FRAC : exp_ch(c) ? FS_E : FS_DEAD;
            FS_E: return sign_ch(c) ? FS_ESIGN : digit_ch(c) ? FS_EXP : FS_DEAD;
            FS_ESIGN, FS_EXP: return digit_ch(c) ? FS_EXP : FS_DEAD;
            default: return FS_DEAD;
        endcase
    endfunction

    function automatic bit word_is(input string w);
        if (lx_count != 16'(w.len())) return 1'b0;
        for (int i = 0; i < w.len(); i++)
            if (lx_lead[i] != w[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [4:0] word_kind();
        logic [7:0] c0, c1, c2;
        bit         px;
        c0 = lx_lead[0];
        c1 = lx_lead[1];
        c2 = lx_lead[2];
        px = lx_count >= 16'd3 && c0 == "0";
        if (lx_fs == FS_INT || lx_fs == FS_FRAC || lx_fs == FS_EXP) return KIND_NUMBER;
        if (px && c1 == "x" && lx_hex) return KIND_NUMBER;
        if (px && c1 == "b" && lx_bin) return KIND_NUMBER;
        if (word_is("true") || word_is("false")) return KIND_BOOL;
        if (lx_count >= 16'd3 && c0 == "'" && c1 >= 8'd32 && c1 <= 8'd126 && c2 == "'")
            return KIND_CHAR;
        if (word_is("define")) return KIND_DEFINE;
        if (word_is("let")) return KIND_LET;
        if (word_is("cond")) return KIND_COND;
        if (word_is("if")) return KIND_IF;
        if (word_is("begin")) return KIND_BEGIN;
        if (sign_ch(c0) || c0 == ".") return (lx_count == 16'd1) ? KIND_IDENT : KIND_ERROR;
        if ((lower_ch(c0) || c0 == "!" || c0 == "*" || c0 == "/" || c0 == ":" ||
             c0 == "<" || c0 == "=" || c0 == ">" || c0 == "?") && lx_idt)
            return KIND_IDENT;
        return KIND_ERROR;
    endfunction

    task automatic add_token(input logic [4:0] k, input logic [15:0] r,
                             input logic [15:0] c, input logic [15:0] n);
        step_tokens.push_back('{kind: k, row: r, col: c, len: n, last: 1'b0});
    endtask

    task automatic clear_lexer();
        lx_mode = MODE_IDLE;
        lx_line = 16'd1;
        lx_col = 16'd0;
        lx_tok_row = 16'd1;
        lx_tok_col = 16'd0;
        lx_count = 16'd0;
        foreach (lx_lead[i]) lx_lead[i] = 8'd0;
        lx_fs = FS_START;
        {lx_hex, lx_bin, lx_idt, lx_sok, lx_esc, lx_eq} = 6'b111100;
    endtask

    task automatic open_token();
        lx_tok_row = lx_line;
        lx_tok_col = lx_col;
        lx_count = 16'd0;
        foreach (lx_lead[i]) lx_lead[i] = 8'd0;
        lx_fs = FS_START;
        {lx_hex, lx_bin, lx_idt, lx_sok, lx_esc, lx_eq} = 6'b111100;
    endtask

    task automatic grow_word(input logic [7:0] c);
        lx_fs = number_step(lx_fs, c);
        if (lx_count >= 16'd2) begin
            if (!(digit_ch(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
                lx_hex = 1'b0;
            if (c != "0" && c != "1") lx_bin = 1'b0;
        end
        if (lx_count >= 16'd1 && !(lower_ch(c) || digit_ch(c) || c == "." || sign_ch(c)))
            lx_idt = 1'b0;
        if (lx_count < 16'd6) lx_lead[3'(lx_count)] = c;
        lx_count = bump(lx_count);
    endtask

    task automatic between_tokens(input logic [7:0] c);
        logic [4:0] bk;
        if (blank_ch(c)) return;
        if (c == CH_TILDE) begin
            lx_mode = MODE_COMMENT;
        end else if (brack_ch(c, bk)) begin
            add_token(bk, lx_line, lx_col, 16'd1);
        end else if (c == CH_QUOTE) begin
            open_token();
            lx_count = 16'd1;
            lx_mode = MODE_STRING;
        end else begin
            open_token();
            grow_word(c);
            lx_mode = MODE_WORD;
        end
    endtask

    // Advances the token model by one accepted request and queues its tokens.
    task automatic lex_byte(input logic [7:0] c, input logic eoi);
        logic [4:0] bk;
        step_tokens.delete();
        if (eoi) begin
            if (lx_mode == MODE_WORD) begin
                add_token(word_kind(), lx_tok_row, lx_tok_col, lx_count);
            end else if (lx_mode == MODE_STRING) begin
                add_token((lx_count == 16'd1 || (!lx_esc && lx_eq && lx_sok)) ?
                          KIND_STRING : KIND_ERROR, lx_tok_row, lx_tok_col, lx_count);
            end
            clear_lexer();
        end else begin
            if (c == CH_NL) begin
                lx_line = bump(lx_line);
                lx_col = 16'd0;
            end else begin
                lx_col = bump(lx_col);
            end
            case (lx_mode)
                MODE_COMMENT: if (c == CH_NL) lx_mode = MODE_IDLE;
                MODE_STRING: begin
                    lx_count = bump(lx_count);
                    if (lx_esc) begin
                        if (c != CH_QUOTE && c != CH_BSL && c != "n" && c != "r" && c != "t")
                            lx_sok = 1'b0;
                        lx_esc = 1'b0;
                        lx_eq = (c == CH_QUOTE);
                    end else if (c == CH_QUOTE) begin
                        add_token(lx_sok ? KIND_STRING : KIND_ERROR, lx_tok_row,
                                  lx_tok_col, lx_count);
                        lx_mode = MODE_IDLE;
                    end else if (c == CH_BSL) begin
                        lx_esc = 1'b1;
                        lx_eq = 1'b0;
                    end else begin
                        if (c < 8'd32 || c > 8'd126) lx_sok = 1'b0;
                        lx_eq = 1'b0;
                    end
                end
                MODE_WORD: begin
                    if (blank_ch(c) || brack_ch(c, bk)) begin
                        add_token(word_kind(), lx_tok_row, lx_tok_col, lx_count);
                        lx_mode = MODE_IDLE;
                        if (!blank_ch(c)) between_tokens(c);
                    end else begin
                        grow_word(c);
                    end
                end
                default: between_tokens(c);
            endcase
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endtask

    task automatic put_byte(input logic [7:0] c);
        pending_bytes.push_back('{ch: c, eoi: 1'b0});
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    endtask

    task automatic put_eoi();
        pending_bytes.push_back('{ch: 8'($urandom_range(0, 255)), eoi: 1'b1});
    endtask

    function automatic string pick(input string opts[$]);
        return opts[$urandom_range(0, opts.size() - 1)];
    endfunction

    function automatic string digit_run(input string alphabet, input int n);
        string s = "";
        for (int i = 0; i < n; i++) s = {s, alphabet.substr(0, 0)};
        for (int i = 0; i < n; i++) s[i] = alphabet[$urandom_range(0, alphabet.len() - 1)];
        return s;
    endfunction

    // One random token with well-formed content most of the time.
    task automatic put_random_token();
        string s;
        case ($urandom_range(0, 11))
            0: s = digit_run("0123456789", $urandom_range(1, 5));
            1: s = {pick('{"", "+", "-"}), digit_run("0123456789", $urandom_range(0, 3)),
                    pick('{"", ".5", ".", ".25"}), pick('{"", "e3", "E-7", "e+", "e"})};
            2: s = {"0x", digit_run("0123456789abcdefABCDEFg", $urandom_range(0, 4))};
            3: s = {"0b", digit_run("0123", $urandom_range(0, 5))};
            4: s = pick('{"true", "false", "define", "let", "cond", "if", "begin",
                          "truex", "lets", "+", "-", ".", "+e5", "e5", "+a"});
            5: s = {"'", digit_run("ab ~'\\", 1), "'", digit_run("xy", $urandom_range(0, 2))};
            6: s = {digit_run("abcz!*/:<=>?", 1),
                    digit_run("abcxyz09.+-", $urandom_range(0, 6))};
            7: s = {"x", digit_run("aQ_#", $urandom_range(1, 3))};
            8: s = {"\"", digit_run("ab ~(\t", $urandom_range(0, 4)),
                    pick('{"", "\\n", "\\\"", "\\q", "\\\\", "\\t"}),
                    digit_run("cd", $urandom_range(0, 2)), "\""};
            9: s = {"~", digit_run("ab \"(", $urandom_range(0, 5)), "\n"};
            10: s = digit_run("()[]{}", $urandom_range(1, 3));
            default: s = "";
        endcase
        put_text(s);
        if (s.len() == 0) begin
            put_byte(8'($urandom_range(0, 255)));
        end else if ($urandom_range(0, 3) == 0) begin
            put_byte(8'($urandom_range(0, 255)));
        end
        case ($urandom_range(0, 5))
            0: put_byte(CH_NL);
            1: put_text(digit_run("()[]{}", 1));
            2: put_text(digit_run("\t\r\v\f ", 1));
            default: put_byte(8'd32);
        endcase
        if ($urandom_range(0, 40) == 0) put_eoi();
    endtask

    // Driver: a new request is presented only once the previous one was taken.
    always @(posedge i_clk) byte_taken <= i_valid && o_ready;

    always @(negedge i_clk) begin
        src_item_t it;
        if (running && (!i_valid || byte_taken)) begin
            if (src_gap > 0) begin
                src_gap <= src_gap - 1;
                i_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
                it = pending_bytes.pop_front();
                i_char_byte <= it.ch;
                i_end_of_input <= it.eoi;
                i_valid <= 1'b1;
                if (gaps_on && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 19);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so the token queue fills.
    always @(negedge i_clk) begin
        if (!running) begin
            i_ready <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            i_ready <= 1'b0;
        end else if (!hold_done && accepted_count >= 400) begin
            hold_done <= 1'b1;
            sink_gap <= 300;
            i_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 15) == 0) begin
            sink_gap <= $urandom_range(0, 18);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Monitor: results are checked before this edge's request updates the model.
    always @(posedge i_clk) begin
        token_t want;
        if (running && o_valid && i_ready) begin
            if (expected_tokens.size() == 0) begin
                $error("unexpected token kind=%0d row=%0d col=%0d len=%0d",
                       o_token_kind, o_start_row, o_start_column, o_token_length);
                error_count++;
            end else begin
                want = expected_tokens.pop_front();
                if (o_token_kind !== want.kind) begin
                    $error("token_kind expected %0d actual %0d", want.kind, o_token_kind);
                    error_count++;
                end
                if (o_start_row !== want.row) begin
                    $error("start_row expected %0d actual %0d", want.row, o_start_row);
                    error_count++;
                end
                if (o_start_column !== want.col) begin
                    $error("start_column expected %0d actual %0d", want.col, o_start_column);
                    error_count++;
                end
                if (o_token_length !== want.len) begin
                    $error("token_length expected %0d actual %0d", want.len, o_token_length);
                    error_count++;
                end
                if (o_last_of_run !== want.last) begin
                    $error("last_of_run expected %0d actual %0d", want.last, o_last_of_run);
                    error_count++;
                end
            end
        end
        if (running && i_valid && o_ready) begin
            lex_byte(i_char_byte, i_end_of_input);
            accepted_count++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        clear_lexer();
        // Directed: brackets, number forms, booleans, char, keywords, strings, comment.
        put_text("()[]{} 0x1F 0b10 -1.5e+3] +e5 true 'a'x define let cond if begin ");
        put_text("+ .5e .x \"a\\n\\q\" ~c(\n\"\\\"");
        put_eoi();
        put_text("\"\x01\"");
        put_byte(8'd0);
        put_byte(8'hFF);
        put_eoi();
        put_text("\"\"");
        put_eoi();
        put_text("(x");
        put_eoi();
        while (pending_bytes.size() < 1000) put_random_token();
        put_eoi();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        running <= 1'b1;
        wait (pending_bytes.size() < 150);
        gaps_on = 1'b0;
        wait (pending_bytes.size() == 0 && !i_valid);
        wait (expected_tokens.size() == 0);
        repeat (20) @(posedge i_clk);
        if (expected_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", expected_tokens.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

### lisp_token_lexer.f
+incdir+rtl
rtl/ltl_pkg.sv
rtl/ltl_scanner.sv
rtl/ltl_queue.sv
rtl/lisp_token_lexer.sv
verif/lisp_token_lexer_tb.sv
